FILE: hdl/ird_pkg.sv
// Shared types and constants of the indexed ring deque.
package ird_pkg;

  localparam int WORD_W      = 32;
  localparam int POSITION_W  = 7;
  localparam int OUT_COUNT_W = 7;
  localparam int KIND_W      = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_READ   = 3'd2,
    KIND_WRITE  = 3'd3,
    KIND_SEARCH = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_RIGHT,
    CELL_FROM_LEFT,
    CELL_LOAD_NEW
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

FILE: hdl/indexed_ring_deque_core.sv
// Top level of the indexed ring deque: control sequencer and the chain of storage cells.
//
// The block keeps an ordered list of up to CAPACITY words. One input transaction
// carries a kind, a position and a data word; each one yields exactly one result
// transaction with ok, result_word and the element count after the operation.
// Elements live in a row of cells in list order, so cell i holds index i.
// Insert opens a gap in the shift state, with every cell above the position taking its
// left neighbor. Read, write, search and remove rotate the whole row once, one
// cell per cycle, and inspect the word passing cell 0; a remove then closes the
// gap in the shift state. Insert goes from idle to the shift state, read, write and
// search to the scan state, and remove to the scan and then the shift state; clear
// and rejected operations go straight to the done state, which loads the output
// register. A new transaction is taken only in the idle state, after the result of
// the last one has left the done state.
// A new transaction is taken while an earlier result still waits at the output;
// if the receiver stalls, the finished result waits until the output register
// frees up. Reset empties the list and drops any pending result.
module indexed_ring_deque_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ird_pkg::KIND_W-1:0]           in_kind,
  input  logic [ird_pkg::POSITION_W-1:0]       in_position,
  input  logic [ird_pkg::WORD_W-1:0]           in_data_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_ok,
  output logic [ird_pkg::WORD_W-1:0]           out_result_word,
  output logic [ird_pkg::OUT_COUNT_W-1:0]      out_count
);
  import ird_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
  localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CMP_W-1:0] CAP_EXT = CMP_W'(CAPACITY);

  state_t                  state_r, state_nxt;
  logic [KIND_W-1:0]       kind_r, kind_nxt;
  logic [CMP_W-1:0]        pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0]   word_r, word_nxt;
  logic                    ok_r, ok_nxt;
  logic [DATA_WIDTH-1:0]   res_r, res_nxt;
  logic [IDX_W-1:0]        step_r, step_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_ok_r, out_ok_nxt;
  logic [WORD_W-1:0]       out_word_r, out_word_nxt;
  logic [OUT_COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic [CMP_W-1:0]        pos_in;
  logic [CMP_W-1:0]        count_ext;
  logic [CMP_W-1:0]        step_ext;
  logic [DATA_WIDTH-1:0]   word_in;
  logic [DATA_WIDTH-1:0]   ring_feed;

  logic [DATA_WIDTH-1:0]   cell_q  [CAPACITY];
  logic [DATA_WIDTH-1:0]   left_d  [CAPACITY];
  logic [DATA_WIDTH-1:0]   right_d [CAPACITY];
  cell_op_t                cell_op [CAPACITY];

  assign pos_in    = CMP_W'(in_position);
  assign count_ext = CMP_W'(count_r);
  assign step_ext  = CMP_W'(step_r);
  assign word_in   = DATA_WIDTH'(in_data_word);

  assign ring_feed = (state_r == ST_SCAN && kind_r == KIND_WRITE && step_ext == pos_r) ?
                     word_r : cell_q[0];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      localparam logic [CMP_W-1:0] IDX = CMP_W'(gi);

      if (gi == 0) begin : g_first
        assign left_d[gi] = word_r;
      end else begin : g_inner_left
        assign left_d[gi] = cell_q[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_d[gi] = ring_feed;
      end else begin : g_inner_right
        assign right_d[gi] = cell_q[gi+1];
      end

      always_comb begin
        cell_op[gi] = CELL_HOLD;
        if (state_r == ST_SCAN) begin
          cell_op[gi] = CELL_FROM_RIGHT;
        end else if (state_r == ST_SHIFT) begin
          if (kind_r == KIND_INSERT) begin
            if (IDX > pos_r) begin
              cell_op[gi] = CELL_FROM_LEFT;
            end else if (IDX == pos_r) begin
              cell_op[gi] = CELL_LOAD_NEW;
            end
          end else if (IDX >= pos_r) begin
            cell_op[gi] = CELL_FROM_RIGHT;
          end
        end
      end

      ird_cell #(
        .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk    (clk),
        .op     (cell_op[gi]),
        .left_d (left_d[gi]),
        .right_d(right_d[gi]),
        .new_d  (word_r),
        .q      (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    pos_nxt       = pos_r;
    word_nxt      = word_r;
    ok_nxt        = ok_r;
    res_nxt       = res_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_ok_nxt    = out_ok_r;
    out_word_nxt  = out_word_r;
    out_count_nxt = out_count_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          pos_nxt   = pos_in;
          word_nxt  = word_in;
          ok_nxt    = 1'b0;
          res_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DONE;
          case (kind_t'(in_kind))
            KIND_INSERT: begin
              if (count_ext < CAP_EXT && pos_in <= count_ext) begin
                state_nxt = ST_SHIFT;
              end
            end
            KIND_REMOVE, KIND_READ, KIND_WRITE: begin
              if (pos_in < count_ext) begin
                state_nxt = ST_SCAN;
              end
            end
            KIND_SEARCH: state_nxt = ST_SCAN;
            KIND_CLEAR: begin
              count_nxt = '0;
              ok_nxt    = 1'b1;
            end
            default: ok_nxt = 1'b0;
          endcase
        end
      end
      ST_SCAN: begin
        if (kind_r == KIND_SEARCH) begin
          if (step_ext < count_ext && cell_q[0] == word_r) begin
            ok_nxt = 1'b1;
          end
        end else if (step_ext == pos_r) begin
          res_nxt = cell_q[0];
          ok_nxt  = 1'b1;
        end
        if (step_r == STEP_LAST) begin
          step_nxt  = '0;
          state_nxt = (kind_r == KIND_REMOVE) ? ST_SHIFT : ST_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_SHIFT: begin
        if (kind_r == KIND_INSERT) begin
          count_nxt = count_r + 1'b1;
          ok_nxt    = 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_word_nxt  = WORD_W'(res_r);
          out_count_nxt = OUT_COUNT_W'(count_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    pos_r       <= pos_nxt;
    word_r      <= word_nxt;
    ok_r        <= ok_nxt;
    res_r       <= res_nxt;
    out_ok_r    <= out_ok_nxt;
    out_word_r  <= out_word_nxt;
    out_count_r <= out_count_nxt;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_result_word = out_word_r;
  assign out_count       = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count exceeds capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && kind_r == KIND_INSERT) |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not raise the count by one");

  a_scan_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && step_r == STEP_LAST) |=> (step_r == '0 && state_r != ST_SCAN))
    else $error("rotation did not end after a full turn");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ready) ##1 out_valid_r |-> $past(state_r) == ST_DONE)
    else $error("result loaded outside the done state");

  a_scan_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && state_nxt == ST_SCAN) |-> step_nxt == '0)
    else $error("rotation started at a nonzero step");

endmodule

FILE: hdl/ird_cell.sv
// One storage cell of the deque chain, loading from either neighbor or a new word.
module ird_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  ird_pkg::cell_op_t     op,
  input  logic [DATA_WIDTH-1:0] left_d,
  input  logic [DATA_WIDTH-1:0] right_d,
  input  logic [DATA_WIDTH-1:0] new_d,
  output logic [DATA_WIDTH-1:0] q
);
  import ird_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    case (op)
      CELL_HOLD:       data_nxt = data_r;
      CELL_FROM_RIGHT: data_nxt = right_d;
      CELL_FROM_LEFT:  data_nxt = left_d;
      CELL_LOAD_NEW:   data_nxt = new_d;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule
